/* rtl/core/gcws_pkg.sv */
package gcws_pkg;

  localparam int unsigned MaxWindow  = 256;
  localparam int unsigned MaxSeqLen  = 65536;

  localparam int unsigned BaseW      = 8;
  localparam int unsigned PctW       = 7;
  localparam int unsigned WinW       = $clog2(MaxWindow + 1);
  localparam int unsigned IdxW       = $clog2(MaxWindow);
  localparam int unsigned PosW       = $clog2(MaxSeqLen + 2);
  localparam int unsigned CountW     = 9;
  localparam int unsigned StartW     = 16;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 9;
  localparam int unsigned ProdW      = PctW + WinW;
  localparam int unsigned OutDataW   = 32;

  // x / 100 as (x * Recip100) >> DivShift, exact for x below 43690
  localparam int unsigned DivShift   = 21;
  localparam int unsigned RecipW     = 15;
  localparam logic [RecipW-1:0] Recip100 = RecipW'(20972);
  localparam logic [PctW-1:0]   PctFull  = PctW'(100);

  localparam logic [BaseW-1:0] BaseG = 8'h47;
  localparam logic [BaseW-1:0] BaseC = 8'h43;

  localparam logic [WinW-1:0]   WinMax   = WinW'(MaxWindow);
  localparam logic [PosW-1:0]   PosLimit = PosW'(MaxSeqLen);
  localparam logic [PosW-1:0]   PosOver  = PosW'(MaxSeqLen + 1);
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [PctW-1:0] GcMinReset  = PctW'(0);
  localparam logic [PctW-1:0] GcMaxReset  = PctW'(100);
  localparam logic [WinW-1:0] WinReset    = WinW'(20);

  typedef enum logic [CfgIdxW-1:0] {
    CfgGcMin   = 2'd0,
    CfgGcMax   = 2'd1,
    CfgWinSize = 2'd2
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    StPass    = 2'd0,
    StFail    = 2'd1,
    StShort   = 2'd2,
    StTooLong = 2'd3
  } status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

/* rtl/core/gc_content_window_screen.sv */
// Channel   Dir  Signals                        Payload
// s_axis    in   tvalid/tready/tdata/tlast      tdata[7:0] base, tlast last_base
// m_axis    out  tvalid/tready/tdata            tdata[1:0] status, [17:2] win_start,
//                                               [26:18] gc_total, [31:27] zero
// cfg       in   cfg_we_i/cfg_idx_i/cfg_data_i  0 min G/C percent, 1 max G/C percent,
//                                               2 window length
//
// One request per cycle unless input is held; a result reaches the output register through the
// issue stage after its last character is accepted. The mark ring is a 1-bit RAM read on accept;
// the count is updated and the mark written back from the issue stage, with the last write
// forwarded. A config write holds input through the write, the remainder start, the remainder
// steps for the ring index (position mod window) and its load. Reset clears all sequence state,
// not the ring. Input also stalls while a last character waits on an unread previous result.
module gc_content_window_screen (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gcws_pkg::BaseW-1:0]      s_axis_tdata,   // [7:0] base
  input  logic                            s_axis_tlast,   // last_base

  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gcws_pkg::OutDataW-1:0]   m_axis_tdata,   // [1:0] status, [17:2] win_start,
                                                          // [26:18] gc_total

  input  logic                            cfg_we_i,
  input  logic [gcws_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [gcws_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned MulW = gcws_pkg::ProdW + gcws_pkg::RecipW;

  // configuration
  logic [gcws_pkg::PctW-1:0] min_pct_q, max_pct_q;
  logic [gcws_pkg::WinW-1:0] win_q;
  logic                      start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pct_q <= gcws_pkg::GcMinReset;
      max_pct_q <= gcws_pkg::GcMaxReset;
      win_q     <= gcws_pkg::WinReset;
      start_q   <= 1'b0;
    end else begin
      start_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gcws_pkg::CfgGcMin:   min_pct_q <= cfg_data_i[gcws_pkg::PctW-1:0];
          gcws_pkg::CfgGcMax:   max_pct_q <= cfg_data_i[gcws_pkg::PctW-1:0];
          gcws_pkg::CfgWinSize: win_q     <= cfg_data_i[gcws_pkg::WinW-1:0];
          default: ;
        endcase
      end
    end
  end

  logic [gcws_pkg::WinW-1:0] w_eff;
  logic [gcws_pkg::PctW-1:0] min_eff, max_eff;

  always_comb begin
    if (win_q == '0) begin
      w_eff = gcws_pkg::WinW'(1);
    end else if (win_q > gcws_pkg::WinMax) begin
      w_eff = gcws_pkg::WinMax;
    end else begin
      w_eff = win_q;
    end
    min_eff = (min_pct_q > gcws_pkg::PctFull) ? gcws_pkg::PctFull : min_pct_q;
    max_eff = (max_pct_q > gcws_pkg::PctFull) ? gcws_pkg::PctFull : max_pct_q;
  end

  // window bounds: percent * W, then divide by 100 via reciprocal
  logic [gcws_pkg::ProdW-1:0] lo_prod_q, hi_prod_q;
  logic [MulW-1:0]            lo_mul, hi_mul;
  logic [gcws_pkg::WinW-1:0]  lo_q, hi_q;

  assign lo_mul = MulW'(lo_prod_q) * MulW'(gcws_pkg::Recip100);
  assign hi_mul = MulW'(hi_prod_q) * MulW'(gcws_pkg::Recip100);

  always_ff @(posedge clk_i) begin
    lo_prod_q <= gcws_pkg::ProdW'(min_eff) * gcws_pkg::ProdW'(w_eff);
    hi_prod_q <= gcws_pkg::ProdW'(max_eff) * gcws_pkg::ProdW'(w_eff);
    lo_q      <= gcws_pkg::WinW'(lo_mul >> gcws_pkg::DivShift);
    hi_q      <= gcws_pkg::WinW'(hi_mul >> gcws_pkg::DivShift);
  end

  // sequence state
  logic [gcws_pkg::PosW-1:0]   pos_q, pos_d;
  logic [gcws_pkg::CountW-1:0] count_q, count_d;
  logic                        failed_q, failed_d;
  logic [gcws_pkg::StartW-1:0] fstart_q, fstart_d;
  logic [gcws_pkg::CountW-1:0] fcount_q, fcount_d;

  // ring index recompute after config writes
  gcws_pkg::rem_stat_t       rem_stat;
  logic [gcws_pkg::IdxW-1:0] rem_idx;

  gcws_rem u_rem (
    .clk_i,
    .rst_ni,
    .start_i    (start_q),
    .dividend_i (pos_q),
    .divisor_i  (w_eff),
    .stat_o     (rem_stat),
    .rem_o      (rem_idx)
  );

  // hold input until the recomputed ring index is loaded
  logic busy;
  assign busy = cfg_we_i | start_q | rem_stat.busy | rem_stat.done;

  // issue stage
  logic                      s1_valid_q, s1_last_q, s1_mark_q;
  logic [gcws_pkg::IdxW-1:0] s1_idx_q;
  logic [gcws_pkg::IdxW-1:0] idx_q;
  logic [gcws_pkg::WinW-1:0] idx_inc;
  logic                      stall, accept, s1_go;
  logic                      out_valid_q;

  assign stall         = s1_valid_q & s1_last_q & out_valid_q & ~m_axis_tready;
  assign s_axis_tready = ~stall & ~busy;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s1_go         = s1_valid_q & ~stall;
  assign idx_inc       = gcws_pkg::WinW'(idx_q) + gcws_pkg::WinW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (rem_stat.done) begin
        idx_q <= rem_idx;
      end else if (accept) begin
        if (s_axis_tlast || idx_inc >= w_eff) begin
          idx_q <= '0;
        end else begin
          idx_q <= gcws_pkg::IdxW'(idx_inc);
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= s_axis_tlast;
      s1_mark_q <= (s_axis_tdata == gcws_pkg::BaseG) || (s_axis_tdata == gcws_pkg::BaseC);
      s1_idx_q  <= idx_q;
    end
  end

  // mark ring
  logic                      ram_we;
  logic [0:0]                ram_rdata;
  logic                      fwd_valid_q, fwd_mark_q;
  logic [gcws_pkg::IdxW-1:0] fwd_idx_q;
  logic                      old_mark;

  gcws_ram #(
    .Width (1),
    .Depth (gcws_pkg::MaxWindow)
  ) u_ring (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (s1_idx_q),
    .wdata_i (s1_mark_q),
    .re_i    (accept),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign old_mark = (fwd_valid_q && fwd_idx_q == s1_idx_q) ? fwd_mark_q : ram_rdata[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (ram_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_mark_q <= s1_mark_q;
    end
  end

  // update stage
  logic [gcws_pkg::PosW-1:0]   w_pos;
  logic [gcws_pkg::CountW-1:0] cnt_dec;
  logic [gcws_pkg::StatusW-1:0] res_status;
  logic [gcws_pkg::StartW-1:0]  res_start;
  logic [gcws_pkg::CountW-1:0]  res_count;

  assign w_pos = gcws_pkg::PosW'(w_eff);

  always_comb begin
    pos_d    = pos_q;
    count_d  = count_q;
    failed_d = failed_q;
    fstart_d = fstart_q;
    fcount_d = fcount_q;
    ram_we   = 1'b0;
    cnt_dec  = count_q;
    if (s1_go) begin
      if (pos_q < gcws_pkg::PosLimit) begin
        if (pos_q >= w_pos && old_mark && count_q != '0) begin
          cnt_dec = count_q - gcws_pkg::CountW'(1);
        end
        if (s1_mark_q && cnt_dec != gcws_pkg::CountMax) begin
          count_d = cnt_dec + gcws_pkg::CountW'(1);
        end else begin
          count_d = cnt_dec;
        end
        ram_we = 1'b1;
        pos_d  = pos_q + gcws_pkg::PosW'(1);
        if (pos_d >= w_pos && !failed_q) begin
          if (gcws_pkg::WinW'(count_d) < lo_q || gcws_pkg::WinW'(count_d) > hi_q) begin
            failed_d = 1'b1;
            fstart_d = gcws_pkg::StartW'(pos_d - w_pos);
            fcount_d = count_d;
          end
        end
      end else begin
        pos_d = gcws_pkg::PosOver;
      end
    end
  end

  always_comb begin
    if (pos_d > gcws_pkg::PosLimit) begin
      res_status = gcws_pkg::StTooLong;
      res_start  = '0;
      res_count  = '0;
    end else if (pos_d < w_pos) begin
      res_status = gcws_pkg::StShort;
      res_start  = '0;
      res_count  = '0;
    end else if (failed_d) begin
      res_status = gcws_pkg::StFail;
      res_start  = fstart_d;
      res_count  = fcount_d;
    end else begin
      res_status = gcws_pkg::StPass;
      res_start  = gcws_pkg::StartW'(pos_d - w_pos);
      res_count  = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      count_q  <= '0;
      failed_q <= 1'b0;
      fstart_q <= '0;
      fcount_q <= '0;
    end else if (s1_go && s1_last_q) begin
      // end of sequence: start over
      pos_q    <= '0;
      count_q  <= '0;
      failed_q <= 1'b0;
      fstart_q <= '0;
      fcount_q <= '0;
    end else begin
      pos_q    <= pos_d;
      count_q  <= count_d;
      failed_q <= failed_d;
      fstart_q <= fstart_d;
      fcount_q <= fcount_d;
    end
  end

  // output register
  logic [gcws_pkg::StatusW-1:0] out_status_q;
  logic [gcws_pkg::StartW-1:0]  out_start_q;
  logic [gcws_pkg::CountW-1:0]  out_count_q;
  logic                         out_load;

  assign out_load = s1_go & s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status;
      out_start_q  <= res_start;
      out_count_q  <= res_count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = gcws_pkg::OutDataW'({out_count_q, out_start_q, out_status_q});

endmodule

/* rtl/core/gcws_ram.sv */
module gcws_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/core/gcws_rem.sv */
// Position modulo window size, one dividend bit per cycle (restoring).
module gcws_rem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gcws_pkg::PosW-1:0]     dividend_i,
  input  logic [gcws_pkg::WinW-1:0]     divisor_i,
  output gcws_pkg::rem_stat_t           stat_o,
  output logic [gcws_pkg::IdxW-1:0]     rem_o
);

  localparam int unsigned CntW = $clog2(gcws_pkg::PosW + 1);

  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [gcws_pkg::PosW-1:0] sh_q, sh_d;
  logic [gcws_pkg::IdxW-1:0] rem_q, rem_d;
  logic                      done_q, done_d;
  logic [gcws_pkg::WinW-1:0] trial;

  always_comb begin
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    trial  = {rem_q, sh_q[gcws_pkg::PosW-1]};
    if (start_i) begin
      cnt_d = CntW'(gcws_pkg::PosW);
      sh_d  = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      // shift in the next bit, subtract when it fits
      if (trial >= divisor_i) begin
        rem_d = gcws_pkg::IdxW'(trial - divisor_i);
      end else begin
        rem_d = gcws_pkg::IdxW'(trial);
      end
      sh_d   = {sh_q[gcws_pkg::PosW-2:0], 1'b0};
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gcws_pkg::*;

  localparam int unsigned SettleCycles = 16;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RandomItems  = 250;
  localparam int unsigned PctCap       = 100;

  localparam logic [BaseW-1:0] BaseA    = 8'h41;
  localparam logic [BaseW-1:0] BaseT    = 8'h54;
  localparam logic [BaseW-1:0] BaseLowG = 8'h67;
  localparam logic [BaseW-1:0] BaseLowC = 8'h63;

  typedef enum int {PatGc, PatAt, PatAlt, PatMix, PatNoise} pattern_e;

  typedef struct packed {
    status_e             status;
    logic [StartW-1:0]   start;
    logic [CountW-1:0]   gc;
  } screen_res_t;

  typedef struct {
    bit          wr_cfg;
    int unsigned pmin, pmax, win;
    int unsigned len;
    pattern_e    pat;
    int unsigned mid_at;           // 0: no change inside the sequence
    int unsigned mmin, mmax, mwin;
    bit          typed;
    screen_res_t res;
  } seq_case_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [BaseW-1:0]    s_axis_tdata = '0;    // [7:0] base
  logic                s_axis_tlast = 1'b0;  // last_base
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [1:0] status, [17:2] win_start, [26:18] gc_total
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgGcMin;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  gc_content_window_screen u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4ns clk_i = 1'b1;
    #4ns clk_i = 1'b0;
  end

  // screening model state
  int unsigned pct_min = 0;
  int unsigned pct_max = 100;
  int unsigned win_cfg = 20;
  bit          gc_ring [MaxWindow];
  int unsigned seq_pos = 0;
  int unsigned gc_run = 0;
  bit          fail_seen = 1'b0;
  int unsigned fail_at = 0;
  int unsigned fail_gc = 0;

  screen_res_t expected_reports [$];
  bit          use_typed = 1'b0;
  screen_res_t typed_res;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned err_cnt = 0;

  seq_case_t dir_cases [15] = '{
    '{1'b0,   0, 100,  20,    20, PatGc,     0,  0,   0,   0, 1'b1, '{StPass,    16'd0,     9'd20}},
    '{1'b0,   0, 100,  20,    19, PatGc,     0,  0,   0,   0, 1'b1, '{StShort,   16'd0,      9'd0}},
    '{1'b1,   0, 100,   1,     1, PatGc,     0,  0,   0,   0, 1'b1, '{StPass,    16'd0,      9'd1}},
    '{1'b1,   0, 100,   0,     3, PatAt,     0,  0,   0,   0, 1'b1, '{StPass,    16'd2,      9'd0}},
    '{1'b1, 127, 127, 511,   256, PatGc,     0,  0,   0,   0, 1'b1, '{StPass,    16'd0,    9'd256}},
    '{1'b1, 100, 100, 256,   300, PatMix,    0,  0,   0,   0, 1'b0, '{StPass,    16'd0,      9'd0}},
    '{1'b1,  50,  50,   4,     4, PatAlt,    0,  0,   0,   0, 1'b1, '{StPass,    16'd0,      9'd2}},
    '{1'b1,  50,  60,  10,    30, PatAt,     0,  0,   0,   0, 1'b1, '{StFail,    16'd0,      9'd0}},
    '{1'b1,   0,   0,  10,    12, PatGc,     0,  0,   0,   0, 1'b1, '{StFail,    16'd0,     9'd10}},
    '{1'b1,  30,  70,  16,    40, PatMix,   20, 10,  90,  16, 1'b0, '{StPass,    16'd0,      9'd0}},
    '{1'b1,  20,  80,  32,    60, PatMix,   40, 20,  80,  12, 1'b0, '{StPass,    16'd0,      9'd0}},
    '{1'b1,   0, 100,   4,   230, PatMix,   10,  0, 100, 200, 1'b0, '{StPass,    16'd0,      9'd0}},
    '{1'b1,  40,  60,  20,    45, PatNoise,  0,  0,   0,   0, 1'b0, '{StPass,    16'd0,      9'd0}},
    '{1'b1,   0, 100,   2,     1, PatGc,     0,  0,   0,   0, 1'b1, '{StShort,   16'd0,      9'd0}},
    '{1'b1,  25,  75,   8,    24, PatMix,    0,  0,   0,   0, 1'b0, '{StPass,    16'd0,      9'd0}}
  };

  // Advance the model by one character; returns 1 when a report is due.
  function automatic bit screen_char(input logic [BaseW-1:0] b, input bit last,
                                     output screen_res_t r);
    int unsigned w, lo, hi, idx;
    bit mark;
    w = (win_cfg == 0) ? 1 : (win_cfg > MaxWindow) ? MaxWindow : win_cfg;
    r = '0;
    if (seq_pos < MaxSeqLen) begin
      mark = (b == BaseG) || (b == BaseC);
      idx = seq_pos % w;
      if (seq_pos >= w && gc_ring[idx] && gc_run > 0) gc_run--;
      if (mark && gc_run < int'(CountMax)) gc_run++;
      gc_ring[idx] = mark;
      seq_pos++;
      if (seq_pos >= w && !fail_seen) begin
        lo = ((pct_min > PctCap ? PctCap : pct_min) * w) / PctCap;
        hi = ((pct_max > PctCap ? PctCap : pct_max) * w) / PctCap;
        if (gc_run < lo || gc_run > hi) begin
          fail_seen = 1'b1;
          fail_at = seq_pos - w;
          fail_gc = gc_run;
        end
      end
    end else begin
      seq_pos = MaxSeqLen + 1;
    end
    if (!last) return 1'b0;
    if (seq_pos > MaxSeqLen) begin
      r.status = StTooLong;
    end else if (seq_pos < w) begin
      r.status = StShort;
    end else if (fail_seen) begin
      r.status = StFail;
      r.start  = StartW'(fail_at);
      r.gc     = CountW'(fail_gc);
    end else begin
      r.status = StPass;
      r.start  = StartW'(seq_pos - w);
      r.gc     = CountW'(gc_run);
    end
    seq_pos = 0;
    gc_run = 0;
    fail_seen = 1'b0;
    fail_at = 0;
    fail_gc = 0;
    return 1'b1;
  endfunction

  function automatic logic [BaseW-1:0] pick_base(input pattern_e pat, input int unsigned i,
                                                 input int unsigned gc_pct);
    logic [BaseW-1:0] b;
    case (pat)
      PatGc:    b = i[0] ? BaseC : BaseG;
      PatAt:    b = i[0] ? BaseT : BaseA;
      PatAlt:   b = i[0] ? BaseA : BaseG;
      PatNoise: b = BaseW'($urandom_range(255));
      default: begin
        if ($urandom_range(99) < 10) begin
          b = BaseW'($urandom_range(255));
        end else if ($urandom_range(99) < gc_pct) begin
          b = $urandom_range(1) ? BaseG : BaseC;
        end else begin
          case ($urandom_range(3))
            0:       b = BaseA;
            1:       b = BaseT;
            2:       b = BaseLowG;
            default: b = BaseLowC;
          endcase
        end
      end
    endcase
    return b;
  endfunction

  task automatic send_char(input logic [BaseW-1:0] b, input bit last);
    screen_res_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (screen_char(b, last, res)) begin
      expected_reports.push_back(use_typed ? typed_res : res);
      use_typed = 1'b0;
    end
  endtask

  // Drop valid and wait until every pending request is out and the block is quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned pmin, input int unsigned pmax,
                            input int unsigned win);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgGcMin;
    cfg_data_i <= CfgDataW'(pmin);
    @(posedge clk_i);
    cfg_idx_i  <= CfgGcMax;
    cfg_data_i <= CfgDataW'(pmax);
    @(posedge clk_i);
    cfg_idx_i  <= CfgWinSize;
    cfg_data_i <= CfgDataW'(win);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    pct_min = pmin & 'h7F;
    pct_max = pmax & 'h7F;
    win_cfg = win & 'h1FF;
  endtask

  // report checker and output back-pressure
  initial begin
    screen_res_t got, want;
    int unsigned hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tdata[StatusW-1:0]);
        got.start  = m_axis_tdata[StatusW +: StartW];
        got.gc     = m_axis_tdata[StatusW+StartW +: CountW];
        if (expected_reports.size() == 0) begin
          $error("unexpected report: status %0d, win_start %0d, gc_total %0d",
                 got.status, got.start, got.gc);
          err_cnt++;
        end else begin
          want = expected_reports.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_cnt++;
          end
          if (got.start !== want.start) begin
            $error("win_start: expected %0d, got %0d", want.start, got.start);
            err_cnt++;
          end
          if (got.gc !== want.gc) begin
            $error("gc_total: expected %0d, got %0d", want.gc, got.gc);
            err_cnt++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // end the run if nothing moves on either side for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned rnd_items, seq_no, len, win, w_eff, pmin, pmax, gc_pct, r;
    bit pressed;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 35;
    rx_idle_pct = 86;
    foreach (dir_cases[c]) begin
      if (dir_cases[c].wr_cfg) begin
        settle();
        set_config(dir_cases[c].pmin, dir_cases[c].pmax, dir_cases[c].win);
      end
      use_typed = dir_cases[c].typed;
      typed_res = dir_cases[c].res;
      for (int unsigned i = 0; i < dir_cases[c].len; i++) begin
        if (dir_cases[c].mid_at != 0 && i == dir_cases[c].mid_at) begin
          settle();
          set_config(dir_cases[c].mmin, dir_cases[c].mmax, dir_cases[c].mwin);
        end
        send_char(pick_base(dir_cases[c].pat, i, 50), i == dir_cases[c].len - 1);
      end
    end

    rnd_items = 0;
    seq_no = 0;
    pressed = 1'b0;
    w_eff = 1;
    while (rnd_items < RandomItems) begin
      if (rnd_items < RandomItems / 3) begin
        tx_idle_pct = 35;
        rx_idle_pct = 86;
      end else if (rnd_items < 2 * RandomItems / 3) begin
        tx_idle_pct = 86;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        if (!pressed) begin
          // stall the output while single-character sequences keep coming
          pressed = 1'b1;
          settle();
          set_config(0, 100, 1);
          w_eff = 1;
          hold_req <= hold_req + 1;
          for (int unsigned k = 0; k < 32; k++) send_char(pick_base(PatMix, k, 50), 1'b1);
        end
      end

      if (seq_no % 4 == 0) begin
        r = $urandom_range(99);
        if (r < 70)      win = $urandom_range(24, 1);
        else if (r < 85) win = $urandom_range(64, 25);
        else if (r < 90) win = 0;
        else if (r < 95) win = $urandom_range(256, 200);
        else             win = $urandom_range(511, 257);
        if ($urandom_range(99) < 15) begin
          pmin = $urandom_range(127);
          pmax = $urandom_range(127);
        end else begin
          pmin = $urandom_range(70);
          pmax = $urandom_range(127, 30);
        end
        settle();
        set_config(pmin, pmax, win);
        w_eff = (win == 0) ? 1 : (win > MaxWindow) ? MaxWindow : win;
      end

      r = $urandom_range(99);
      if (r < 10)      len = $urandom_range(w_eff, 1);
      else if (r < 15) len = $urandom_range(3, 1);
      else             len = $urandom_range(2 * w_eff + 8, w_eff);
      gc_pct = $urandom_range(100);
      for (int unsigned i = 0; i < len; i++) send_char(pick_base(PatMix, i, gc_pct), i == len - 1);
      rnd_items += len;
      seq_no++;
    end

    settle();
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
